>>> hdl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
// No dependencies; used by ole_ctrl, ole_datapath and ordered_list_engine.
`default_nettype none

package ole_pkg;

   localparam int CAPACITY_DEF = 32;
   localparam int POS_W        = 6;
   localparam int COUNT_W      = 6;

   typedef enum logic [2:0] {
      OP_APPEND   = 3'd0,
      OP_PREPEND  = 3'd1,
      OP_INSERT   = 3'd2,
      OP_DELETE   = 3'd3,
      OP_COUNT    = 3'd4,
      OP_READ_ALL = 3'd5
   } ole_op_type;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_MISS  = 2'd2,
      STAT_EMPTY = 2'd3
   } ole_status_type;

   // where a freshly allocated node gets linked in
   typedef enum logic [1:0] {
      ALLOC_APPEND = 2'd0,
      ALLOC_FRONT  = 2'd1,
      ALLOC_AFTER  = 2'd2
   } ole_alloc_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INS_WALK,
      ST_ALLOC,
      ST_LINK,
      ST_DEL_WALK,
      ST_UNLINK,
      ST_DONE_RSP,
      ST_MISS_RSP,
      ST_READ
   } ole_state_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
      logic [POS_W-1:0]   position;
   } ole_req_type;

   typedef struct packed {
      ole_status_type     status;
      logic signed [31:0] value_res;
      logic [COUNT_W-1:0] count;
      logic               last;
   } ole_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic           capture;
      logic           walk_init;
      logic           walk_adv;
      logic           alloc;
      ole_alloc_type  alloc_mode;
      logic           link_fix;
      logic           unlink;
      logic           emit;
      ole_status_type emit_status;
      logic           emit_elem;
      logic           emit_last;
   } ole_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [2:0] op;
      logic       full;
      logic       empty;
      logic       pos_ok;
      logic       pos_first;
      logic       pos_hit;
      logic       match;
      logic       at_tail;
      logic       out_free;
   } ole_flags_type;

endpackage

`default_nettype wire

>>> hdl/ole_ctrl.sv
// Sequencer for the ordered list engine: one operation at a time.
// Depends on ole_pkg; drives ole_datapath through ole_cmd_type.
`default_nettype none

module ole_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output ole_pkg::ole_cmd_type       cmd,
   input  wire ole_pkg::ole_flags_type flags
);
   import ole_pkg::*;

   ole_state_type  state_ff, state_in;
   logic           dec_reply;
   ole_status_type dec_status;
   ole_state_type  dec_work;

   // what the decode cycle does with the captured operation
   always_comb begin
      dec_reply  = 1'b1;
      dec_status = STAT_DONE;
      dec_work   = ST_ALLOC;
      case (flags.op)
         OP_APPEND, OP_PREPEND: begin
            if (flags.full) dec_status = STAT_FULL;
            else dec_reply = 1'b0;
         end
         OP_INSERT: begin
            if (flags.full) begin
               dec_status = STAT_FULL;
            end else if (!flags.pos_ok) begin
               dec_status = STAT_MISS;
            end else begin
               dec_reply = 1'b0;
               dec_work  = flags.pos_first ? ST_ALLOC : ST_INS_WALK;
            end
         end
         OP_DELETE: begin
            if (flags.empty) begin
               dec_status = STAT_MISS;
            end else begin
               dec_reply = 1'b0;
               dec_work  = ST_DEL_WALK;
            end
         end
         OP_COUNT: dec_status = STAT_DONE;
         OP_READ_ALL: begin
            if (flags.empty) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_reply = 1'b0;
               dec_work  = ST_READ;
            end
         end
         default: dec_status = STAT_MISS;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (!dec_reply) state_in = dec_work;
            else if (flags.out_free) state_in = ST_IDLE;
         end
         ST_INS_WALK: if (flags.pos_hit) state_in = ST_ALLOC;
         ST_ALLOC: begin
            if (flags.op == OP_INSERT && !flags.pos_first) state_in = ST_LINK;
            else state_in = ST_DONE_RSP;
         end
         ST_LINK:     state_in = ST_DONE_RSP;
         ST_DEL_WALK: begin
            if (flags.match) state_in = ST_UNLINK;
            else if (flags.at_tail) state_in = ST_MISS_RSP;
         end
         ST_UNLINK:   state_in = ST_DONE_RSP;
         ST_DONE_RSP, ST_MISS_RSP: if (flags.out_free) state_in = ST_IDLE;
         ST_READ:     if (flags.out_free && flags.at_tail) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.alloc_mode  = ALLOC_AFTER;
      cmd.emit_status = STAT_DONE;
      cmd.emit_last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            cmd.walk_init   = 1'b1;
            cmd.emit        = dec_reply && flags.out_free;
            cmd.emit_status = dec_status;
         end
         ST_INS_WALK: cmd.walk_adv = !flags.pos_hit;
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (flags.op == OP_APPEND) cmd.alloc_mode = ALLOC_APPEND;
            else if (flags.op == OP_PREPEND || flags.pos_first) cmd.alloc_mode = ALLOC_FRONT;
            else cmd.alloc_mode = ALLOC_AFTER;
         end
         ST_LINK:     cmd.link_fix = 1'b1;
         ST_DEL_WALK: cmd.walk_adv = !flags.match && !flags.at_tail;
         ST_UNLINK:   cmd.unlink = 1'b1;
         ST_DONE_RSP: cmd.emit = flags.out_free;
         ST_MISS_RSP: begin
            cmd.emit        = flags.out_free;
            cmd.emit_status = STAT_MISS;
         end
         ST_READ: begin
            cmd.emit      = flags.out_free;
            cmd.emit_elem = 1'b1;
            cmd.emit_last = flags.at_tail;
            cmd.walk_adv  = flags.out_free && !flags.at_tail;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

>>> hdl/ole_datapath.sv
// Datapath of the ordered list engine: node and link memories, free-slot
// stack, list pointers, walk registers and the result register. Uses ole_pkg.
`default_nettype none

module ole_datapath #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ole_pkg::ole_req_type  req_payload,
   input  wire ole_pkg::ole_cmd_type  cmd,
   output ole_pkg::ole_flags_type     flags,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output ole_pkg::ole_rsp_type       rsp_payload
);
   import ole_pkg::*;

   localparam int IW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   ole_req_type req_ff;

   logic [IW-1:0] first_ff, first_in, end_ff, end_in;
   logic [IW-1:0] cur_ff, cur_in, prev_ff, prev_in, step_ff, step_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic [CW-1:0] count_ff, count_in, fresh_ff, fresh_in, ftop_ff, ftop_in;

   logic signed [31:0] element_mem_ff [CAPACITY];
   logic [IW-1:0]      link_mem_ff    [CAPACITY];
   logic [IW-1:0]      free_mem_ff    [CAPACITY];
   logic signed [31:0] elem_rd_ff;
   logic [IW-1:0]      link_rd_ff, free_rd_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   ole_rsp_type   rsp_ff;

   logic [CW-1:0]   ftop_m1;
   logic [IW-1:0]   alloc_slot;
   logic [CMPW-1:0] count_x, pos_x, step1_x, step2_x;

   logic          link_we;
   logic [IW-1:0] link_wa, link_wd;

   assign ftop_m1    = ftop_ff - CW'(1);
   assign alloc_slot = (ftop_ff != '0) ? free_rd_ff : fresh_ff[IW-1:0];

   assign count_x = CMPW'(count_ff);
   assign pos_x   = CMPW'(req_ff.position);
   assign step1_x = CMPW'(step_ff) + CMPW'(1);
   assign step2_x = CMPW'(step_ff) + CMPW'(2);

   always_comb begin
      flags.op        = req_ff.op;
      flags.full      = (count_ff == CW'(CAPACITY));
      flags.empty     = (count_ff == '0);
      flags.pos_ok    = (pos_x != '0) && (pos_x <= count_x);
      flags.pos_first = (pos_x == CMPW'(1));
      flags.pos_hit   = (step2_x == pos_x);
      flags.match     = (elem_rd_ff == req_ff.value);
      flags.at_tail   = (step1_x == count_x);
      flags.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      first_in = first_ff;
      end_in   = end_ff;
      cur_in   = cur_ff;
      prev_in  = prev_ff;
      step_in  = step_ff;
      slot_in  = slot_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      ftop_in  = ftop_ff;
      link_we  = 1'b0;
      link_wa  = alloc_slot;
      link_wd  = link_rd_ff;

      if (cmd.walk_init) begin
         cur_in  = first_ff;
         prev_in = first_ff;
         step_in = '0;
      end
      if (cmd.walk_adv) begin
         prev_in = cur_ff;
         cur_in  = link_rd_ff;
         step_in = step_ff + IW'(1);
      end

      if (cmd.alloc) begin
         slot_in  = alloc_slot;
         count_in = count_ff + CW'(1);
         if (ftop_ff != '0) ftop_in = ftop_m1;
         else fresh_in = fresh_ff + CW'(1);
         case (cmd.alloc_mode)
            ALLOC_APPEND: begin
               if (count_ff == '0) first_in = alloc_slot;
               else begin
                  link_we = 1'b1;
                  link_wa = end_ff;
                  link_wd = alloc_slot;
               end
               end_in = alloc_slot;
            end
            ALLOC_FRONT: begin
               if (count_ff == '0) end_in = alloc_slot;
               first_in = alloc_slot;
               link_we  = 1'b1;
               link_wd  = first_ff;
            end
            default: begin
               // new node takes the successor of the node at cur
               link_we = 1'b1;
            end
         endcase
      end

      if (cmd.link_fix) begin
         link_we = 1'b1;
         link_wa = cur_ff;
         link_wd = slot_ff;
      end

      if (cmd.unlink) begin
         count_in = count_ff - CW'(1);
         ftop_in  = ftop_ff + CW'(1);
         if (step_ff == '0) first_in = link_rd_ff;
         else begin
            link_we = 1'b1;
            link_wa = prev_ff;
         end
         if (step1_x == count_x) end_in = prev_ff;
      end
   end

   // node and link memories: reads track cur_in so the read data matches cur_ff
   always_ff @(posedge clock) begin
      if (cmd.alloc) element_mem_ff[alloc_slot] <= req_ff.value;
      elem_rd_ff <= element_mem_ff[cur_in];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem_ff[link_wa] <= link_wd;
      link_rd_ff <= link_mem_ff[cur_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.unlink) free_mem_ff[ftop_ff[IW-1:0]] <= cur_ff;
      free_rd_ff <= free_mem_ff[ftop_m1[IW-1:0]];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         end_ff       <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         ftop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         end_ff       <= end_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         ftop_ff      <= ftop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      prev_ff <= prev_in;
      step_ff <= step_in;
      slot_ff <= slot_in;
      if (cmd.capture) req_ff <= req_payload;
      if (cmd.emit) begin
         rsp_ff.status    <= cmd.emit_status;
         rsp_ff.value_res <= cmd.emit_elem ? elem_rd_ff : 32'sd0;
         rsp_ff.count     <= count_x[COUNT_W-1:0];
         rsp_ff.last      <= cmd.emit_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

>>> hdl/ordered_list_engine.sv
// Ordered list engine: bounded linked list of signed 32-bit values.
// Top level; instantiates ole_ctrl and ole_datapath, uses ole_pkg.
//
// Usage:
//   req_ channel carries one operation (append, prepend, insert at a 1-based
//   position, delete by value, count, read all). rsp_ channel returns one
//   transaction per operation, or one per stored entry for read all, with
//   last set on the final one. Both channels are valid/ready.
//   Operations run one at a time. Count and error replies come straight from
//   decode; append, prepend and insert at 1 allocate and link without a walk;
//   insert at a later position and delete first walk the list, and read all
//   returns one entry per cycle while the receiver is ready.
//   Walks go through the link memory, one node per cycle through its
//   registered read port. Next operation is accepted the cycle after the
//   last result is registered.
//   Reset empties the list at once; no clearing pass is needed.
//   A stalled receiver holds the result register; a read-out walk stops
//   with it and other operations wait at their reply.
`default_nettype none

module ordered_list_engine #(
   parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ole_pkg::ole_req_type req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ole_pkg::ole_rsp_type      rsp_payload
);
   import ole_pkg::*;

   ole_cmd_type   cmd;
   ole_flags_type flags;

   ole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .flags     (flags)
   );

   ole_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .flags       (flags),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // anything but a normal reply is a single, last transaction
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STAT_DONE) |-> rsp_payload.last)
      else $error("error status without last");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == STAT_EMPTY) |-> (rsp_payload.count == '0))
      else $error("empty status with nonzero count");

   // no new operation while a read-out is still producing entries
   a_no_accept_midread: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> !req_ready)
      else $error("request accepted during read-out");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != STAT_DONE) |-> (rsp_payload.value_res == 32'sd0))
      else $error("nonzero value on error reply");

endmodule

`default_nettype wire

>>> sim/list_tracker_pkg.sv
// Scoreboard for the ordered list engine: keeps a shadow copy of the list
// and the queue of awaited responses. Depends on ole_pkg.
package list_tracker_pkg;
   import ole_pkg::*;

   class list_tracker;
      logic signed [31:0] shadow_list[$];
      ole_rsp_type        awaited_rsp[$];
      int unsigned        fail_count = 0;

      task report_mismatch(string msg);
         $display("mismatch: %s", msg);
         fail_count++;
      endtask

      function int pending();
         return awaited_rsp.size();
      endfunction

      // count is sampled after the list update, as the block reports it
      function void push_rsp(ole_status_type status, logic signed [31:0] elem, logic last);
         ole_rsp_type rsp;
         rsp.status    = status;
         rsp.value_res = elem;
         rsp.count     = COUNT_W'(shadow_list.size());
         rsp.last      = last;
         awaited_rsp.push_back(rsp);
      endfunction

      function void apply_request(ole_req_type req);
         bit full;
         int hit;
         full = shadow_list.size() >= CAPACITY_DEF;
         hit  = -1;
         case (req.op)
            OP_APPEND, OP_PREPEND: begin
               if (full) begin
                  push_rsp(STAT_FULL, '0, 1'b1);
               end else begin
                  if (req.op == OP_APPEND) begin
                     shadow_list.push_back(req.value);
                  end else begin
                     shadow_list.push_front(req.value);
                  end
                  push_rsp(STAT_DONE, '0, 1'b1);
               end
            end
            OP_INSERT: begin
               // a full list wins over a bad position
               if (full) begin
                  push_rsp(STAT_FULL, '0, 1'b1);
               end else if (req.position == 0 || req.position > shadow_list.size()) begin
                  push_rsp(STAT_MISS, '0, 1'b1);
               end else begin
                  shadow_list.insert(int'(req.position) - 1, req.value);
                  push_rsp(STAT_DONE, '0, 1'b1);
               end
            end
            OP_DELETE: begin
               foreach (shadow_list[i]) begin
                  if (hit < 0 && shadow_list[i] == req.value) hit = i;
               end
               if (hit < 0) begin
                  push_rsp(STAT_MISS, '0, 1'b1);
               end else begin
                  shadow_list.delete(hit);
                  push_rsp(STAT_DONE, '0, 1'b1);
               end
            end
            OP_COUNT: begin
               push_rsp(STAT_DONE, '0, 1'b1);
            end
            OP_READ_ALL: begin
               if (shadow_list.size() == 0) begin
                  push_rsp(STAT_EMPTY, '0, 1'b1);
               end else begin
                  foreach (shadow_list[i]) begin
                     push_rsp(STAT_DONE, shadow_list[i], i == shadow_list.size() - 1);
                  end
               end
            end
            default: begin
               // undefined op codes: rejected, list untouched
               push_rsp(STAT_MISS, '0, 1'b1);
            end
         endcase
      endfunction

      task check_response(ole_rsp_type got);
         ole_rsp_type want;
         if (awaited_rsp.size() == 0) begin
            report_mismatch($sformatf("unexpected rsp: status %0d value %0d count %0d last %0d",
                                      got.status, got.value_res, got.count, got.last));
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
         end
         if (got.value_res !== want.value_res) begin
            report_mismatch($sformatf("value_res %0d, want %0d", got.value_res, want.value_res));
         end
         if (got.count !== want.count) begin
            report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
         end
         if (got.last !== want.last) begin
            report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
         end
      endtask
   endclass

endpackage

>>> sim/ordered_list_engine_test.sv
// Testbench top for ordered_list_engine: directed and random list operations
// under varying idle/stall pressure. Depends on ole_pkg and list_tracker_pkg.
module ordered_list_engine_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ole_pkg::*;
   import list_tracker_pkg::*;

   localparam logic [2:0]         OP_UNUSED_A  = 3'd6;
   localparam logic [2:0]         OP_UNUSED_B  = 3'd7;
   localparam logic signed [31:0] VAL_MAX      = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN      = 32'sh8000_0000;
   localparam int                 QUIET_LIMIT  = 2000;
   localparam int                 DRAIN_CYCLES = 40;
   localparam int                 PHASE_ITEMS  = 90;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   ole_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b1;
   ole_rsp_type rsp_payload;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;
   list_tracker board;

   ordered_list_engine dut (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_payload,
      .rsp_valid,
      .rsp_ready,
      .rsp_payload
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: check accepted transactions, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_payload);
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("** ordered_list_engine: FAILED **");
      $finish;
   end

   function automatic ole_req_type make_req(logic [2:0] op, logic signed [31:0] value,
                                            logic [POS_W-1:0] position);
      ole_req_type req;
      req.op       = op;
      req.value    = value;
      req.position = position;
      return req;
   endfunction

   // small values make duplicates and delete hits likely
   function automatic logic signed [31:0] pick_value();
      int unsigned size;
      size = board.shadow_list.size();
      case ($urandom_range(3))
         0: return int'($urandom_range(8)) - 4;
         1: begin
            if (size > 0) return board.shadow_list[$urandom_range(size - 1)];
            return $urandom();
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic ole_req_type next_random_req(bit grow);
      int unsigned edges[6];
      int unsigned roll, size, pick;
      ole_req_type req;
      size = board.shadow_list.size();
      if (grow) begin
         edges = '{40, 60, 80, 88, 94, 97};
      end else begin
         edges = '{10, 15, 25, 80, 90, 95};
      end
      roll = $urandom_range(99);
      pick = 0;
      foreach (edges[i]) begin
         if (roll >= edges[i]) pick = i + 1;
      end
      req.value    = $urandom();
      req.position = POS_W'($urandom_range(63));
      case (pick)
         0: req.op = OP_APPEND;
         1: req.op = OP_PREPEND;
         2: req.op = OP_INSERT;
         3: req.op = OP_DELETE;
         4: req.op = OP_READ_ALL;
         5: req.op = OP_COUNT;
         default: req.op = $urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B;
      endcase
      if (req.op == OP_APPEND || req.op == OP_PREPEND || req.op == OP_INSERT) begin
         req.value = pick_value();
      end
      if (req.op == OP_INSERT && $urandom_range(4) != 0) begin
         req.position = POS_W'($urandom_range(size + 1));
      end
      if (req.op == OP_DELETE) begin
         if (size > 0 && $urandom_range(3) != 0) begin
            req.value = board.shadow_list[$urandom_range(size - 1)];
         end else begin
            req.value = pick_value();
         end
      end
      return req;
   endfunction

   // valid is only lowered when an idle gap is taken, so it never drops and
   // rises within one step
   task automatic send_req(ole_req_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      board.apply_request(item);
   endtask

   initial begin
      int unsigned phase, n, grow_items;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases
      send_req(make_req(OP_READ_ALL, 32'sd0, 6'd0));
      send_req(make_req(OP_DELETE, 32'sd5, 6'd0));
      send_req(make_req(OP_INSERT, 32'sd9, 6'd1));
      send_req(make_req(OP_COUNT, 32'sd0, 6'd0));
      // extremes of value, then positions at and beyond the bounds
      send_req(make_req(OP_APPEND, VAL_MAX, 6'd0));
      send_req(make_req(OP_PREPEND, VAL_MIN, 6'd0));
      send_req(make_req(OP_INSERT, 32'sd1, 6'd0));
      send_req(make_req(OP_INSERT, 32'sd1, 6'd3));
      send_req(make_req(OP_INSERT, -32'sd1, 6'd1));
      send_req(make_req(OP_INSERT, 32'sd0, 6'd3));
      send_req(make_req(OP_INSERT, 32'sd1, 6'd63));
      send_req(make_req(OP_UNUSED_A, 32'sd0, 6'd0));
      send_req(make_req(OP_UNUSED_B, -32'sd1, 6'd63));
      send_req(make_req(OP_READ_ALL, 32'sd0, 6'd0));
      // delete middle, tail, absent, then append after a tail removal
      send_req(make_req(OP_DELETE, VAL_MIN, 6'd0));
      send_req(make_req(OP_DELETE, VAL_MAX, 6'd0));
      send_req(make_req(OP_DELETE, 32'sd42, 6'd0));
      send_req(make_req(OP_APPEND, 32'sd7, 6'd0));
      send_req(make_req(OP_DELETE, -32'sd1, 6'd0));
      // duplicates: only the first match goes
      send_req(make_req(OP_PREPEND, 32'sd7, 6'd0));
      send_req(make_req(OP_DELETE, 32'sd7, 6'd0));
      send_req(make_req(OP_INSERT, 32'sd3, 6'd2));
      send_req(make_req(OP_READ_ALL, 32'sd0, 6'd0));
      send_req(make_req(OP_COUNT, 32'sd0, 6'd0));

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 51;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 51;
            end
            default: begin
               send_idle_pct = 16;
               stall_pct     = 16;
            end
         endcase
         // fill toward capacity, then drain; the last phase drains longer
         grow_items = (phase == 3) ? 30 : 55;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            send_req(next_random_req(n < grow_items));
         end
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.fail_count == 0) begin
         $display("** ordered_list_engine: PASSED **");
      end else begin
         $display("** ordered_list_engine: FAILED **");
      end
      $finish;
   end

endmodule
